// ----- hw/rtl/tfn_pkg.sv -----
// Shared constants for the triangle face normal unit.
package tfn_pkg;

   // Default field widths
   localparam int COORD_BITS_DEFAULT    = 16;
   localparam int MATERIAL_BITS_DEFAULT = 16;

   // Last-material register: fixed width, "no material yet" after reset
   localparam int                  PREV_BITS  = 16;
   localparam logic [PREV_BITS-1:0] PREV_RESET = 16'hFFFF;

   // Result format: sign plus 7-bit magnitude, quotient searched bit by bit
   localparam int NORM_BITS = 8;
   localparam int Q_BITS    = 7;

   // 127^2 = 16129 = 2^14 - 2^8 + 1
   localparam int SCALE_HI_SHIFT = 14;
   localparam int SCALE_LO_SHIFT = 8;

endpackage

// ----- hw/rtl/triangle_face_normal_unit_top.sv -----
// Triangle face normal unit: cross product, length normalization and material-change flag.
//
// Usage
//   req_*  : one triangle per item (three signed vertices, material id), valid/ready.
//   rsp_*  : one result per item: normal scaled to length 127 (truncated toward zero,
//            -127..127) and a flag that is set when the material id differs from the
//            id of the previous triangle. Valid/ready.
//   One item at a time: req_ready is high only while idle, so a new item is taken only
//   once the last one has been loaded into the output register. An accepted item passes
//   through the cross product, the squaring and the length sum, then per component the
//   target and a bit-by-bit quotient search (with an update step after each set bit but
//   the last), and then loads the output register. A triangle whose squared normal length
//   is 0 or 1 skips the target and quotient steps; its components pass through.
//   A single shared multiplier and a single wide adder carry every product, square and
//   trial subtraction in turn.
//   A finished result sits in the output register while the next item is accepted
//   and worked on; if the receiver still stalls when that item is done, the block
//   holds its result and stays busy until the register frees up.
//   Reset (synchronous, active high) drops any item in flight and any pending result
//   and sets the last material id to 65535.
module triangle_face_normal_unit_top #(
   parameter int COORD_BITS    = tfn_pkg::COORD_BITS_DEFAULT,
   parameter int MATERIAL_BITS = tfn_pkg::MATERIAL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_vert0_x,
   input  logic signed [COORD_BITS-1:0]        req_vert0_y,
   input  logic signed [COORD_BITS-1:0]        req_vert0_z,
   input  logic signed [COORD_BITS-1:0]        req_vert1_x,
   input  logic signed [COORD_BITS-1:0]        req_vert1_y,
   input  logic signed [COORD_BITS-1:0]        req_vert1_z,
   input  logic signed [COORD_BITS-1:0]        req_vert2_x,
   input  logic signed [COORD_BITS-1:0]        req_vert2_y,
   input  logic signed [COORD_BITS-1:0]        req_vert2_z,
   input  logic        [MATERIAL_BITS-1:0]     req_material_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tfn_pkg::NORM_BITS-1:0] rsp_normal_x,
   output logic signed [tfn_pkg::NORM_BITS-1:0] rsp_normal_y,
   output logic signed [tfn_pkg::NORM_BITS-1:0] rsp_normal_z,
   output logic                                rsp_material_changed
);

   // Widths: edge, half of a normal component, normal, multiplier operand and product,
   // square, squared length, q*L, remainder, trial value, adder
   localparam int EW = COORD_BITS + 1;
   localparam int H  = COORD_BITS + 1;
   localparam int NW = 2 * COORD_BITS + 2;
   localparam int MB = COORD_BITS + 2;
   localparam int PW = 2 * MB;
   localparam int SW = 4 * COORD_BITS + 2;
   localparam int LW = 4 * COORD_BITS + 4;
   localparam int YW = LW + tfn_pkg::Q_BITS;
   localparam int RW = 4 * COORD_BITS + 16;
   localparam int DW = 4 * COORD_BITS + 17;
   localparam int AW = 4 * COORD_BITS + 18;
   localparam int NB = tfn_pkg::NORM_BITS;
   localparam int QB = tfn_pkg::Q_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CROSS,
      S_SQUARE,
      S_LSUM,
      S_TGT,
      S_TRY,
      S_CMP,
      S_UPD,
      S_DONE
   } state_type;

   // Partial products of a square: lo*lo, hi*lo, hi*hi
   typedef enum logic [1:0] {
      SQ_LL,
      SQ_HL,
      SQ_HH
   } sq_kind_type;

   // Registers and next values
   state_type                      state_ff, state_in;
   logic [3:0]                     cnt_ff, cnt_in;
   logic [1:0]                     comp_ff, comp_in;
   logic [2:0]                     bit_ff, bit_in;
   logic signed [EW-1:0]           a_ff [3];
   logic signed [EW-1:0]           a_in [3];
   logic signed [EW-1:0]           b_ff [3];
   logic signed [EW-1:0]           b_in [3];
   logic signed [NW-1:0]           n_ff [3];
   logic signed [NW-1:0]           n_in [3];
   logic [SW-1:0]                  sq_ff [3];
   logic [SW-1:0]                  sq_in [3];
   logic [LW-1:0]                  l_ff, l_in;
   logic [RW-1:0]                  r_ff, r_in;
   logic [DW-1:0]                  d_ff, d_in;
   logic [YW-1:0]                  y_ff, y_in;
   logic [QB-1:0]                  q_ff, q_in;
   logic signed [NB-1:0]           res_ff [3];
   logic signed [NB-1:0]           res_in [3];
   logic signed [AW-1:0]           acc_ff, acc_in;
   logic signed [PW-1:0]           mul_ff;
   logic                           chg_ff, chg_in;
   logic [tfn_pkg::PREV_BITS-1:0]  prev_ff, prev_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [NB-1:0]           rsp_x_ff, rsp_x_in;
   logic signed [NB-1:0]           rsp_y_ff, rsp_y_in;
   logic signed [NB-1:0]           rsp_z_ff, rsp_z_in;
   logic                           rsp_chg_ff, rsp_chg_in;

   // Shared unit operands and results
   logic signed [MB-1:0]           ma, mb;
   logic signed [AW-1:0]           opa, opb, sum;
   logic                           add_sub;
   logic [1:0]                     nsel;
   logic signed [NW-1:0]           n_rd;
   logic [SW-1:0]                  sq_rd;
   logic signed [MB-1:0]           hi_ext, lo_ext;
   logic [3:0]                     sh_y, sh_l2;
   logic                           fit;
   logic [QB-1:0]                  q_new;
   logic [tfn_pkg::PREV_BITS-1:0]  mat_wide;

   // Squaring schedule
   logic                           iss_on, add_on;
   logic [1:0]                     iss_comp, add_comp;
   sq_kind_type                    iss_kind, add_kind;

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_normal_x         = rsp_x_ff;
   assign rsp_normal_y         = rsp_y_ff;
   assign rsp_normal_z         = rsp_z_ff;
   assign rsp_material_changed = rsp_chg_ff;

   // Single read ports of the component stores
   assign n_rd   = n_ff[nsel];
   assign sq_rd  = sq_ff[comp_ff];
   assign hi_ext = MB'(signed'(n_rd[NW-1:H]));
   assign lo_ext = signed'({1'b0, n_rd[H-1:0]});
   assign sh_y   = {1'b0, bit_ff} + 4'd1;
   assign sh_l2  = {bit_ff, 1'b0};
   assign mat_wide = tfn_pkg::PREV_BITS'(req_material_id);

   // Shared wide adder/subtractor
   assign sum = opa + (add_sub ? ~opb : opb) + AW'(add_sub);

   // Trial outcome: remainder stays non-negative
   assign fit   = !sum[AW-1];
   assign q_new = fit ? (q_ff | (QB'(1) << bit_ff)) : q_ff;

   // Decode the squaring step: issue one partial product, accumulate the one before
   always_comb begin
      iss_on   = 1'b0;
      iss_comp = 2'd0;
      iss_kind = SQ_LL;
      add_on   = 1'b0;
      add_comp = 2'd0;
      add_kind = SQ_LL;
      unique case (cnt_ff)
         4'd0: begin
            iss_on = 1'b1; iss_comp = 2'd0; iss_kind = SQ_LL;
         end
         4'd1: begin
            iss_on = 1'b1; iss_comp = 2'd0; iss_kind = SQ_HL;
            add_on = 1'b1; add_comp = 2'd0; add_kind = SQ_LL;
         end
         4'd2: begin
            iss_on = 1'b1; iss_comp = 2'd0; iss_kind = SQ_HH;
            add_on = 1'b1; add_comp = 2'd0; add_kind = SQ_HL;
         end
         4'd3: begin
            iss_on = 1'b1; iss_comp = 2'd1; iss_kind = SQ_LL;
            add_on = 1'b1; add_comp = 2'd0; add_kind = SQ_HH;
         end
         4'd4: begin
            iss_on = 1'b1; iss_comp = 2'd1; iss_kind = SQ_HL;
            add_on = 1'b1; add_comp = 2'd1; add_kind = SQ_LL;
         end
         4'd5: begin
            iss_on = 1'b1; iss_comp = 2'd1; iss_kind = SQ_HH;
            add_on = 1'b1; add_comp = 2'd1; add_kind = SQ_HL;
         end
         4'd6: begin
            iss_on = 1'b1; iss_comp = 2'd2; iss_kind = SQ_LL;
            add_on = 1'b1; add_comp = 2'd1; add_kind = SQ_HH;
         end
         4'd7: begin
            iss_on = 1'b1; iss_comp = 2'd2; iss_kind = SQ_HL;
            add_on = 1'b1; add_comp = 2'd2; add_kind = SQ_LL;
         end
         4'd8: begin
            iss_on = 1'b1; iss_comp = 2'd2; iss_kind = SQ_HH;
            add_on = 1'b1; add_comp = 2'd2; add_kind = SQ_HL;
         end
         4'd9: begin
            add_on = 1'b1; add_comp = 2'd2; add_kind = SQ_HH;
         end
         default: ;
      endcase
   end

   // Steer the multiplier and the adder for the current step
   always_comb begin
      ma      = '0;
      mb      = '0;
      opa     = '0;
      opb     = '0;
      add_sub = 1'b0;
      nsel    = comp_ff;
      unique case (state_ff)
         S_CROSS: begin
            // n0 = ay*bz - az*by, n1 = az*bx - ax*bz, n2 = ax*by - ay*bx
            unique case (cnt_ff)
               4'd0: begin ma = MB'(a_ff[1]); mb = MB'(b_ff[2]); end
               4'd1: begin ma = MB'(a_ff[2]); mb = MB'(b_ff[1]); end
               4'd2: begin ma = MB'(a_ff[2]); mb = MB'(b_ff[0]); end
               4'd3: begin ma = MB'(a_ff[0]); mb = MB'(b_ff[2]); end
               4'd4: begin ma = MB'(a_ff[0]); mb = MB'(b_ff[1]); end
               4'd5: begin ma = MB'(a_ff[1]); mb = MB'(b_ff[0]); end
               default: ;
            endcase
            opa     = acc_ff;
            opb     = AW'(mul_ff);
            add_sub = 1'b1;
         end
         S_SQUARE: begin
            nsel = iss_comp;
            if (iss_on) begin
               unique case (iss_kind)
                  SQ_LL: begin ma = lo_ext; mb = lo_ext; end
                  SQ_HL: begin ma = hi_ext; mb = lo_ext; end
                  SQ_HH: begin ma = hi_ext; mb = hi_ext; end
                  default: ;
               endcase
            end
            opa = acc_ff;
            unique case (add_kind)
               SQ_HL:   opb = AW'(mul_ff) << (H + 1);
               SQ_HH:   opb = AW'(mul_ff) << (2 * H);
               default: opb = AW'(mul_ff);
            endcase
         end
         S_LSUM: begin
            if (cnt_ff == 4'd0) begin
               opa = AW'(sq_ff[0]);
               opb = AW'(sq_ff[1]);
            end else begin
               opa = acc_ff;
               opb = AW'(sq_ff[2]);
            end
         end
         S_TGT: begin
            // 127^2 * n^2 in two steps
            if (cnt_ff == 4'd0) begin
               opa     = AW'(sq_rd) << tfn_pkg::SCALE_HI_SHIFT;
               opb     = AW'(sq_rd) << tfn_pkg::SCALE_LO_SHIFT;
               add_sub = 1'b1;
            end else begin
               opa = AW'(r_ff);
               opb = AW'(sq_rd);
            end
         end
         S_TRY: begin
            // (q + 2^b)^2 L - q^2 L = 2^(b+1) q L + 4^b L
            opa = AW'(y_ff) << sh_y;
            opb = AW'(l_ff) << sh_l2;
         end
         S_CMP: begin
            opa     = AW'(r_ff);
            opb     = AW'(d_ff);
            add_sub = 1'b1;
         end
         S_UPD: begin
            opa = AW'(y_ff);
            opb = AW'(l_ff) << bit_ff;
         end
         default: ;
      endcase
   end

   // Sequencer: next values of all registers
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      bit_in       = bit_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      sq_in        = sq_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      y_in         = y_ff;
      q_in         = q_ff;
      res_in       = res_ff;
      acc_in       = acc_ff;
      chg_in       = chg_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_chg_in   = rsp_chg_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Take an item: form edges, compare material id
            if (req_valid) begin
               a_in[0]  = EW'(req_vert1_x) - EW'(req_vert0_x);
               a_in[1]  = EW'(req_vert1_y) - EW'(req_vert0_y);
               a_in[2]  = EW'(req_vert1_z) - EW'(req_vert0_z);
               b_in[0]  = EW'(req_vert2_x) - EW'(req_vert0_x);
               b_in[1]  = EW'(req_vert2_y) - EW'(req_vert0_y);
               b_in[2]  = EW'(req_vert2_z) - EW'(req_vert0_z);
               chg_in   = (mat_wide != prev_ff);
               prev_in  = mat_wide;
               cnt_in   = 4'd0;
               state_in = S_CROSS;
            end
         end
         S_CROSS: begin
            // Odd steps load the first product, even steps subtract the second
            if (cnt_ff[0]) begin
               acc_in = AW'(mul_ff);
            end else if (cnt_ff != 4'd0) begin
               n_in[cnt_ff[2:1] - 2'd1] = sum[NW-1:0];
            end
            if (cnt_ff == 4'd6) begin
               cnt_in   = 4'd0;
               state_in = S_SQUARE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_SQUARE: begin
            if (add_on) begin
               unique case (add_kind)
                  SQ_LL:   acc_in = AW'(mul_ff);
                  SQ_HL:   acc_in = sum;
                  SQ_HH:   sq_in[add_comp] = sum[SW-1:0];
                  default: ;
               endcase
            end
            if (cnt_ff == 4'd9) begin
               cnt_in   = 4'd0;
               state_in = S_LSUM;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_LSUM: begin
            if (cnt_ff == 4'd0) begin
               acc_in = sum;
               cnt_in = 4'd1;
            end else begin
               l_in   = sum[LW-1:0];
               cnt_in = 4'd0;
               if (sum > AW'(1)) begin
                  comp_in  = 2'd0;
                  state_in = S_TGT;
               end else begin
                  // Degenerate triangle: components are already -1..1
                  res_in[0] = n_ff[0][NB-1:0];
                  res_in[1] = n_ff[1][NB-1:0];
                  res_in[2] = n_ff[2][NB-1:0];
                  state_in  = S_DONE;
               end
            end
         end
         S_TGT: begin
            r_in = sum[RW-1:0];
            if (cnt_ff == 4'd0) begin
               cnt_in = 4'd1;
            end else begin
               cnt_in   = 4'd0;
               y_in     = '0;
               q_in     = '0;
               bit_in   = 3'(QB - 1);
               state_in = S_TRY;
            end
         end
         S_TRY: begin
            d_in     = sum[DW-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            if (fit) begin
               r_in = sum[RW-1:0];
            end
            q_in = q_new;
            if (bit_ff == 3'd0) begin
               // Component done: apply the sign of n
               res_in[comp_ff] = n_rd[NW-1] ? NB'(0) - NB'(q_new) : NB'(q_new);
               if (comp_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_TGT;
               end
            end else if (fit) begin
               state_in = S_UPD;
            end else begin
               bit_in   = bit_ff - 3'd1;
               state_in = S_TRY;
            end
         end
         S_UPD: begin
            y_in     = sum[YW-1:0];
            bit_in   = bit_ff - 3'd1;
            state_in = S_TRY;
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_ff[0];
               rsp_y_in     = res_ff[1];
               rsp_z_in     = res_ff[2];
               rsp_chg_in   = chg_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= tfn_pkg::PREV_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
      cnt_ff     <= cnt_in;
      comp_ff    <= comp_in;
      bit_ff     <= bit_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      n_ff       <= n_in;
      sq_ff      <= sq_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      d_ff       <= d_in;
      y_ff       <= y_in;
      q_ff       <= q_in;
      res_ff     <= res_in;
      acc_ff     <= acc_in;
      chg_ff     <= chg_in;
      mul_ff     <= ma * mb;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_chg_ff <= rsp_chg_in;
   end

`ifndef SYNTHESIS
   // An accepted item starts the cross product and blocks further items
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CROSS && !req_ready))
      else $error("accepted item did not start the cross product");

   // A finished item always lands in the output register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid || rsp_ready)) |=> (rsp_valid && req_ready))
      else $error("finished item not loaded into the output register");

   // Normals stay within -127..127
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x != 8'sh80 && rsp_normal_y != 8'sh80 &&
                     rsp_normal_z != 8'sh80))
      else $error("normal component out of range");

   // Every trial value is positive once the length exceeds one
   a_trial_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (d_ff != '0 && l_ff > LW'(1)))
      else $error("zero trial value during quotient search");
`endif

endmodule

// ----- sim/tb_triangle_face_normal_unit_top.sv -----
// Self-checking testbench for the triangle face normal unit: random triangles against a predictor.
module tb_triangle_face_normal_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = tfn_pkg::COORD_BITS_DEFAULT;
   localparam int MW          = tfn_pkg::MATERIAL_BITS_DEFAULT;
   localparam int NW          = tfn_pkg::NORM_BITS;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1500;
   localparam int TAIL_CYCLES  = 100;
   localparam int STALL_LIMIT  = 4000;
   localparam int REPORT_LIMIT = 10;

   // coord[0..2] = vertex 0 x/y/z, [3..5] = vertex 1, [6..8] = vertex 2
   typedef struct packed {
      logic [8:0][CW-1:0] coord;
      logic [MW-1:0]      material;
   } triangle_type;

   typedef struct packed {
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] ny;
      logic signed [NW-1:0] nz;
      logic                 changed;
   } normal_result_type;

   // Predicts the normal of each accepted triangle and checks results in order.
   class normal_book;
      normal_result_type expected_normals[$];
      logic [MW-1:0]     last_material;
      int unsigned       error_count;

      function new();
         last_material = tfn_pkg::PREV_RESET;
         error_count   = 0;
      endfunction

      // Largest q in 0..127 with q^2 * len_sq <= 127^2 * n^2, signed like n.
      function logic [NW-1:0] scaled_axis(longint n, bit [127:0] len_sq);
         bit [127:0] mag;
         bit [127:0] target;
         bit [127:0] trial;
         int         q;
         int         t;
         int         b;
         mag    = (n < 0) ? 128'(-n) : 128'(n);
         target = mag * mag * 128'd16129;
         q      = 0;
         for (b = tfn_pkg::Q_BITS - 1; b >= 0; b--) begin
            t     = q | (1 << b);
            trial = len_sq * 128'(t * t);
            if (trial <= target) q = t;
         end
         return (n < 0) ? NW'(0 - q) : NW'(q);
      endfunction

      function void note_triangle(triangle_type tri_in);
         longint            e0[3];
         longint            e1[3];
         longint            n[3];
         bit [127:0]        mag;
         bit [127:0]        len_sq;
         logic [NW-1:0]     axis[3];
         normal_result_type want;
         int                i;
         for (i = 0; i < 3; i++) begin
            e0[i] = longint'($signed(tri_in.coord[3 + i]))
                    - longint'($signed(tri_in.coord[i]));
            e1[i] = longint'($signed(tri_in.coord[6 + i]))
                    - longint'($signed(tri_in.coord[i]));
         end
         n[0] = e0[1] * e1[2] - e0[2] * e1[1];
         n[1] = e0[2] * e1[0] - e0[0] * e1[2];
         n[2] = e0[0] * e1[1] - e0[1] * e1[0];
         len_sq = '0;
         for (i = 0; i < 3; i++) begin
            mag    = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
            len_sq = len_sq + mag * mag;
         end
         // pass degenerate normals through, scale everything else to length 127
         for (i = 0; i < 3; i++) begin
            if (len_sq > 128'd1) axis[i] = scaled_axis(n[i], len_sq);
            else axis[i] = NW'(n[i]);
         end
         want.nx      = axis[0];
         want.ny      = axis[1];
         want.nz      = axis[2];
         want.changed = (tri_in.material != last_material);
         last_material = tri_in.material;
         expected_normals.push_back(want);
      endfunction

      function void check_normal(normal_result_type got);
         normal_result_type want;
         if (expected_normals.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected normal: x=%0d y=%0d z=%0d changed=%0d",
                        got.nx, got.ny, got.nz, got.changed);
            return;
         end
         want = expected_normals.pop_front();
         if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
             got.changed !== want.changed) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("normal mismatch: expected x=%0d y=%0d z=%0d changed=%0d,",
                        want.nx, want.ny, want.nz, want.changed,
                        " got x=%0d y=%0d z=%0d changed=%0d",
                        got.nx, got.ny, got.nz, got.changed);
         end
      endfunction

      function int pending();
         return expected_normals.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_vert0_x = '0;
   logic signed [CW-1:0] req_vert0_y = '0;
   logic signed [CW-1:0] req_vert0_z = '0;
   logic signed [CW-1:0] req_vert1_x = '0;
   logic signed [CW-1:0] req_vert1_y = '0;
   logic signed [CW-1:0] req_vert1_z = '0;
   logic signed [CW-1:0] req_vert2_x = '0;
   logic signed [CW-1:0] req_vert2_y = '0;
   logic signed [CW-1:0] req_vert2_z = '0;
   logic [MW-1:0]        req_material_id = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [NW-1:0] rsp_normal_x;
   logic signed [NW-1:0] rsp_normal_y;
   logic signed [NW-1:0] rsp_normal_z;
   logic                 rsp_material_changed;

   normal_book    book;
   int            stall_cycles = 0;
   logic [MW-1:0] last_sent_material = '0;

   triangle_face_normal_unit_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_vert0_x          (req_vert0_x),
      .req_vert0_y          (req_vert0_y),
      .req_vert0_z          (req_vert0_z),
      .req_vert1_x          (req_vert1_x),
      .req_vert1_y          (req_vert1_y),
      .req_vert1_z          (req_vert1_z),
      .req_vert2_x          (req_vert2_x),
      .req_vert2_y          (req_vert2_y),
      .req_vert2_z          (req_vert2_z),
      .req_material_id      (req_material_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_normal_x         (rsp_normal_x),
      .rsp_normal_y         (rsp_normal_y),
      .rsp_normal_z         (rsp_normal_z),
      .rsp_material_changed (rsp_material_changed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Random idle gap before each item, used by both the sender and the receiver.
   function automatic int pick_gap();
      return int'($urandom_range(0, 19));
   endfunction

   function automatic triangle_type make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                             int x2, int y2, int z2, int mat);
      triangle_type t;
      t.coord[0] = CW'(x0);
      t.coord[1] = CW'(y0);
      t.coord[2] = CW'(z0);
      t.coord[3] = CW'(x1);
      t.coord[4] = CW'(y1);
      t.coord[5] = CW'(z1);
      t.coord[6] = CW'(x2);
      t.coord[7] = CW'(y2);
      t.coord[8] = CW'(z2);
      t.material = MW'(mat);
      return t;
   endfunction

   // Present one triangle and hold it until the block takes it.
   task automatic send_triangle(input triangle_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_vert0_x     <= t.coord[0];
      req_vert0_y     <= t.coord[1];
      req_vert0_z     <= t.coord[2];
      req_vert1_x     <= t.coord[3];
      req_vert1_y     <= t.coord[4];
      req_vert1_z     <= t.coord[5];
      req_vert2_x     <= t.coord[6];
      req_vert2_y     <= t.coord[7];
      req_vert2_z     <= t.coord[8];
      req_material_id <= t.material;
      do @(posedge clock); while (!req_ready);
      book.note_triangle(t);
      last_sent_material = t.material;
   endtask

   task automatic run_directed();
      // degenerate: all zero, and first id equal to the reset id
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 65535));
      // squared length 1: unit components pass through
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 65535));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, -1, 0, 0));
      send_triangle(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
      // squared length 2: smallest scaled case
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1, 1));
      // coincident extreme vertices
      send_triangle(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, 1));
      send_triangle(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767, 32768));
      // widest edges along the axes and diagonals
      send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                             -32768, 32767, -32768, 32767));
      send_triangle(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                             32767, 32767, -32768, 32767));
      send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                             -32768, 32767, 32767, 0));
      send_triangle(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                             32767, 32767, -32768, 65535));
      // collinear vertices
      send_triangle(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9, 2));
      // one component tiny next to a large one
      send_triangle(make_tri(0, 0, 0, 1000, 0, 0, 0, 1000, 1, 2));
      send_triangle(make_tri(-5, 7, -9, 300, -2, 11, -40, 900, -3, 2));
      send_triangle(make_tri(100, -100, 50, 101, -100, 50, 100, -99, 51, 32768));
   endtask

   task automatic run_random();
      triangle_type t;
      int           k;
      int           i;
      int           d;
      int           f;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         for (i = 0; i < 9; i++) t.coord[i] = CW'($urandom);
         case ($urandom_range(0, 9))
            // small offsets around a random vertex: small and degenerate normals
            4, 5, 6: begin
               for (i = 0; i < 3; i++) begin
                  t.coord[3 + i] = CW'(t.coord[i] + $urandom_range(0, 6) - 3);
                  t.coord[6 + i] = CW'(t.coord[i] + $urandom_range(0, 6) - 3);
               end
            end
            // collinear vertices
            7: begin
               f = $urandom_range(0, 6);
               f = f - 3;
               for (i = 0; i < 3; i++) begin
                  d = $urandom_range(0, 200);
                  d = d - 100;
                  t.coord[3 + i] = CW'(int'($signed(t.coord[i])) + d);
                  t.coord[6 + i] = CW'(int'($signed(t.coord[i])) + f * d);
               end
            end
            // coordinates at the extremes
            8: begin
               for (i = 0; i < 9; i++) begin
                  case ($urandom_range(0, 4))
                     0: t.coord[i] = 16'h8000;
                     1: t.coord[i] = 16'h7FFF;
                     2: t.coord[i] = 16'h0000;
                     3: t.coord[i] = 16'hFFFF;
                     default: t.coord[i] = 16'h0001;
                  endcase
               end
            end
            // a repeated vertex
            9: begin
               if ($urandom_range(0, 1) == 0) begin
                  for (i = 0; i < 3; i++) t.coord[3 + i] = t.coord[i];
               end else begin
                  for (i = 0; i < 3; i++) t.coord[6 + i] = t.coord[i];
               end
            end
            default: ;
         endcase
         // repeat the id often so both flag values come up
         case ($urandom_range(0, 3))
            0: t.material = last_sent_material;
            1: t.material = MW'($urandom_range(0, 3));
            2: t.material = MW'($urandom);
            default: t.material = ($urandom_range(0, 1) == 0) ? '1 : '0;
         endcase
         send_triangle(t);
      end
   endtask

   // Main stimulus and final verdict.
   initial begin
      book = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.error_count == 0) $display("triangle_face_normal_unit_top regression: pass");
      else $display("triangle_face_normal_unit_top regression: fail");
      $finish;
   end

   // Receive results with random backpressure.
   initial begin
      int                gap;
      normal_result_type got;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.nx      = rsp_normal_x;
         got.ny      = rsp_normal_y;
         got.nz      = rsp_normal_z;
         got.changed = rsp_material_changed;
         book.check_normal(got);
      end
   end

   // Abort when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("triangle_face_normal_unit_top regression: fail");
         $finish;
      end
   end

endmodule
